// ----- rtl/core/hcfb_pkg.sv -----
package hcfb_pkg;

  localparam logic [7:0] IdleByte      = 8'h00;
  localparam logic [7:0] StartHigh     = 8'hFF;
  localparam logic [7:0] IdentReset    = 8'hD4;
  localparam logic [7:0] LenOverhead   = 8'd2;

  // one input word
  typedef struct packed {
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } hcfb_in_t;

  // one output word
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } hcfb_out_t;

  // byte positions within a frame
  typedef enum logic [3:0] {
    SlotPre     = 4'd0,
    SlotStart0  = 4'd1,
    SlotStart1  = 4'd2,
    SlotLen     = 4'd3,
    SlotLcs     = 4'd4,
    SlotIdent   = 4'd5,
    SlotCmd     = 4'd6,
    SlotPayload = 4'd7,
    SlotDcs     = 4'd8,
    SlotPost    = 4'd9
  } hcfb_slot_e;

  // what one accepted word has to emit
  typedef struct packed {
    logic       hdr;
    logic       pay;
    logic       tail;
    logic [7:0] len;
    logic [7:0] ident;
    logic [7:0] cmd;
    logic [7:0] pbyte;
    logic [7:0] dcs;
  } hcfb_item_t;

endpackage

// ----- rtl/core/hcfb_frame_ctl.sv -----
module hcfb_frame_ctl import hcfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  hcfb_in_t   word_i,
  input  logic [7:0] ident_i,
  output hcfb_item_t item_o
);

  logic       inside_q, inside_d;
  logic [7:0] remain_q, remain_d;
  logic [7:0] sum_q, sum_d;

  logic [7:0] base_sum;
  logic [7:0] new_sum;
  logic [7:0] new_remain;
  logic       has_pay;

  always_comb begin
    item_o     = '0;
    has_pay    = inside_q || (word_i.payload_length != 8'd0);
    base_sum   = inside_q ? sum_q : (ident_i + word_i.command_code);
    new_sum    = has_pay ? (base_sum + word_i.payload_byte) : base_sum;
    new_remain = inside_q ? (remain_q - 8'd1)
                          : (has_pay ? (word_i.payload_length - 8'd1) : 8'd0);

    item_o.hdr   = !inside_q;
    item_o.pay   = has_pay;
    item_o.tail  = (new_remain == 8'd0);
    item_o.len   = word_i.payload_length + LenOverhead;
    item_o.ident = ident_i;
    item_o.cmd   = word_i.command_code;
    item_o.pbyte = word_i.payload_byte;
    item_o.dcs   = 8'd0 - new_sum;

    inside_d = inside_q;
    remain_d = remain_q;
    sum_d    = sum_q;
    if (accept_i) begin
      if (new_remain == 8'd0) begin
        inside_d = 1'b0;
        remain_d = 8'd0;
        sum_d    = 8'd0;
      end else begin
        inside_d = 1'b1;
        remain_d = new_remain;
        sum_d    = new_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      remain_q <= 8'd0;
      sum_q    <= 8'd0;
    end else begin
      inside_q <= inside_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
    end
  end

endmodule

// ----- rtl/core/host_command_frame_builder.sv -----
// Host command frame builder: turns a stream of input words into the bytes of a
// host-to-controller information frame. The first word of a frame carries the
// command code, the payload length and (if the length is not zero) the first
// payload byte; it yields the seven header bytes (preamble, two start codes,
// length = payload_length + 2, length checksum, frame identifier, command),
// then its payload byte. Each later word yields one payload byte. After the
// last payload byte the data checksum and the postamble follow; frame_end
// marks the postamble. An empty payload gives the whole nine-byte frame from
// one word. Rate: a payload word inside a frame is freed as its byte moves out,
// so payload streams at one byte per clock unless the output stalls; a frame's
// first word holds the input until its header bytes (and any payload byte)
// have moved out, a word that closes the frame until its checksum and postamble
// have too. The first byte passes the item register, then the output register.
// The frame identifier register (reset 0xD4) is written via cfg_we_i/cfg_data_i;
// the user must write it only while the block is idle; nothing enforces it.
module host_command_frame_builder import hcfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input words
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  hcfb_in_t   in_data_i,
  // output words
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output hcfb_out_t  out_data_o,
  // frame identifier register
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] ident_q;

  // item register: the descriptor of the word being serialized
  hcfb_item_t item_d, item_q;
  logic       item_valid_q;
  hcfb_slot_e slot_q;

  // output register
  logic       out_valid_q;
  hcfb_out_t  out_q;

  logic       in_accept;
  logic       out_load;
  logic       slot_last;
  hcfb_slot_e slot_next;
  hcfb_out_t  out_d;

  // frame state lives in the control block, updated on every accepted word
  hcfb_frame_ctl u_ctl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .word_i   (in_data_i),
    .ident_i  (ident_q),
    .item_o   (item_d)
  );

  // a valid item loads the output register when it is empty or being drained
  assign out_load  = item_valid_q && (!out_valid_q || out_ready_i);

  // a word's last byte is the postamble if it closes the frame, else its payload
  assign slot_last = item_q.tail ? (slot_q == SlotPost) : (slot_q == SlotPayload);

  // the item register frees up in the cycle its last byte moves out
  assign in_ready_o = !item_valid_q || (out_load && slot_last);
  assign in_accept  = in_valid_i && in_ready_o;

  // skip the payload slot when the frame has no payload
  always_comb begin
    if (slot_q == SlotCmd && !item_q.pay) begin
      slot_next = SlotDcs;
    end else begin
      slot_next = hcfb_slot_e'(slot_q + 4'd1);
    end
  end

  // byte select for the current slot
  always_comb begin
    out_d.frame_end = 1'b0;
    case (slot_q)
      SlotPre:     out_d.frame_byte = IdleByte;
      SlotStart0:  out_d.frame_byte = IdleByte;
      SlotStart1:  out_d.frame_byte = StartHigh;
      SlotLen:     out_d.frame_byte = item_q.len;
      SlotLcs:     out_d.frame_byte = 8'd0 - item_q.len;
      SlotIdent:   out_d.frame_byte = item_q.ident;
      SlotCmd:     out_d.frame_byte = item_q.cmd;
      SlotPayload: out_d.frame_byte = item_q.pbyte;
      SlotDcs:     out_d.frame_byte = item_q.dcs;
      SlotPost: begin
        out_d.frame_byte = IdleByte;
        out_d.frame_end  = 1'b1;
      end
      default:     out_d.frame_byte = IdleByte;
    endcase
  end

  // control: identifier, item valid, slot counter, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q      <= IdentReset;
      item_valid_q <= 1'b0;
      slot_q       <= SlotPre;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ident_q <= cfg_data_i;
      end
      if (in_accept) begin
        item_valid_q <= 1'b1;
        // a word inside a frame starts straight at its payload byte
        slot_q       <= item_d.hdr ? SlotPre : SlotPayload;
      end else if (out_load) begin
        if (slot_last) begin
          item_valid_q <= 1'b0;
        end else begin
          slot_q <= slot_next;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= item_d;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import hcfb_pkg::*;

  // clock, reset and the block's ports
  logic       clk;
  logic       rst_n;
  logic       in_valid = 1'b0;
  logic       in_ready;
  hcfb_in_t   in_data  = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  hcfb_out_t  out_data;
  logic       cfg_we;
  logic [7:0] cfg_data;

  // percentage of cycles in which each side holds back
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // words waiting to be sent, and frame bytes still owed by the block
  hcfb_in_t   word_q[$];
  hcfb_out_t  frame_bytes_q[$];
  int unsigned mismatches;

  // shadow of the block's state: open frame, bytes still to come, checksum sum
  logic       in_frame;
  logic [7:0] bytes_left;
  logic [7:0] byte_sum;
  logic [7:0] ident_reg;

  host_command_frame_builder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // frame byte prediction
  // ---------------------------------------------------------------------------

  // one expected frame byte
  function automatic void owe_byte(logic [7:0] b, logic last);
    hcfb_out_t o;
    o.frame_byte = b;
    o.frame_end  = last;
    frame_bytes_q = {frame_bytes_q, o};
  endfunction

  // a payload byte; the last one also closes the frame with dcs and postamble
  function automatic void owe_payload(logic [7:0] b);
    owe_byte(b, 1'b0);
    byte_sum   = byte_sum + b;
    bytes_left = bytes_left - 8'd1;
    if (bytes_left == 8'd0) begin
      owe_byte(8'(8'h00 - byte_sum), 1'b0);
      owe_byte(IdleByte, 1'b1);
      in_frame = 1'b0;
      byte_sum = 8'h00;
    end
  endfunction

  // bytes that one accepted word should produce
  function automatic void predict_frame_bytes(hcfb_in_t w);
    logic [7:0] len;
    len = 8'(w.payload_length + LenOverhead);
    if (in_frame) begin
      // header fields of a word inside a frame are don't-care
      owe_payload(w.payload_byte);
    end else begin
      owe_byte(IdleByte, 1'b0);
      owe_byte(IdleByte, 1'b0);
      owe_byte(StartHigh, 1'b0);
      owe_byte(len, 1'b0);
      owe_byte(8'(8'h00 - len), 1'b0);
      owe_byte(ident_reg, 1'b0);
      owe_byte(w.command_code, 1'b0);
      byte_sum = 8'(ident_reg + w.command_code);
      if (w.payload_length == 8'd0) begin
        // empty payload closes at once, payload byte ignored
        owe_byte(8'(8'h00 - byte_sum), 1'b0);
        owe_byte(IdleByte, 1'b1);
        byte_sum = 8'h00;
      end else begin
        in_frame   = 1'b1;
        bytes_left = w.payload_length;
        owe_payload(w.payload_byte);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued words, holds each until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      predict_frame_bytes(in_data);
    end
    if (!in_valid || in_ready) begin
      if (rst_n && word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= word_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each taken frame byte against the oldest one owed
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    hcfb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_bytes_q.size() == 0) begin
        report_mismatch("frame byte with none owed", 8'h00, out_data.frame_byte);
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_data.frame_byte !== want.frame_byte)
          report_mismatch("frame_byte", want.frame_byte, out_data.frame_byte);
        if (out_data.frame_end !== want.frame_end)
          report_mismatch("frame_end", 8'(want.frame_end), 8'(out_data.frame_end));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [7:0] cmd, logic [7:0] plen, logic [7:0] pbyte);
    hcfb_in_t w;
    w.command_code   = cmd;
    w.payload_length = plen;
    w.payload_byte   = pbyte;
    word_q = {word_q, w};
  endtask

  // a well-formed frame with random command and payload; the header fields of
  // the later words are random noise the block must ignore
  task automatic queue_frame(int unsigned len);
    push_word(8'($urandom), 8'(len), 8'($urandom));
    for (int unsigned k = 1; k < len; k++)
      word_q = {word_q, hcfb_in_t'(24'($urandom))};
  endtask

  // sender held back until every owed byte has come out
  task automatic wait_drained();
    do @(negedge clk);
    while (word_q.size() != 0 || in_valid || frame_bytes_q.size() != 0);
  endtask

  // only called while the block is idle
  task automatic write_ident(logic [7:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ident_reg = v;
    @(negedge clk);
  endtask

  // mostly short frames, now and then a longer one, with occasional drains
  task automatic random_frames(int unsigned n_words);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(7) == 0) wait_drained();
      pick = $urandom_range(99);
      if (pick < 70)      len = $urandom_range(6);
      else if (pick < 95) len = $urandom_range(20, 7);
      else                len = $urandom_range(40, 21);
      queue_frame(len);
      sent += (len == 0) ? 1 : len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = 8'h00;
    mismatches    = 0;
    in_frame      = 1'b0;
    bytes_left    = 8'h00;
    byte_sum      = 8'h00;
    ident_reg     = IdentReset;
    send_idle_pct = 8;
    recv_idle_pct = 71;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset identifier first
    push_word(8'h00, 8'd0, 8'h00);     // empty payload, all-zero command
    push_word(8'hFF, 8'd0, 8'hA5);     // empty payload, payload byte ignored
    push_word(8'h4A, 8'd1, 8'hFF);     // single byte frame from one word
    push_word(8'h02, 8'd2, 8'h00);
    push_word(8'hFF, 8'hFF, 8'hFF);    // header fields inside a frame ignored
    wait_drained();

    // identifier at its low extreme, checksum wrapping on all-ones bytes
    write_ident(8'h00);
    push_word(8'hFF, 8'd3, 8'hFF);
    push_word(8'h00, 8'h00, 8'hFF);
    push_word(8'h5A, 8'hC3, 8'hFF);
    wait_drained();

    // identifier at its high extreme
    write_ident(8'hFF);
    push_word(8'h01, 8'd0, 8'h00);
    push_word(8'h80, 8'd4, 8'h01);
    push_word(8'h80, 8'h7F, 8'hFE);
    push_word(8'h7F, 8'h80, 8'h7F);
    push_word(8'hAA, 8'h55, 8'h80);
    wait_drained();

    // random, fast sender, slow receiver
    write_ident(8'($urandom));
    random_frames(10);
    wait_drained();
    write_ident(8'($urandom));
    random_frames(10);
    wait_drained();

    // random, the other way round
    send_idle_pct = 71;
    recv_idle_pct = 8;
    write_ident(8'hFF);
    random_frames(10);
    wait_drained();
    write_ident(8'($urandom));
    random_frames(10);
    wait_drained();

    // no idling: the longest frame, where the length byte wraps
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_ident(IdentReset);
    queue_frame(255);
    random_frames(6);
    wait_drained();

    // let any stray byte show up before the verdict
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #(300_000 * 12);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/hcfb_pkg.sv
rtl/core/hcfb_frame_ctl.sv
rtl/core/host_command_frame_builder.sv
tb/tb_top.sv
